[rtl/cgi_pkg.sv]
// ----------------------------------------------------------------------------
// cgi_pkg: shared types and constants of the glyph index lookup
// Item codes, result status codes, the command that the front end hands to
// the back end, the table entry layout and the stream field widths.
// ----------------------------------------------------------------------------
package cgi_pkg;

  localparam int CODE_W      = 32;
  localparam int FLAGS_W     = 8;
  localparam int OFFSET_W    = 32;
  localparam int ENTRY_NUM_W = 12;

  // Stream widths: the input kind travels in tuser, the status in tuser.
  localparam int IN_TDATA_W  = CODE_W + FLAGS_W + OFFSET_W;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_USED_W  = 1 + ENTRY_NUM_W + FLAGS_W + OFFSET_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;
  localparam int OUT_TUSER_W = 3;

  // Depth of the command queue between front and back end.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [IN_TUSER_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [OUT_TUSER_W-1:0] {
    ST_OK    = 3'd0,
    ST_ORDER = 3'd1,
    ST_FULL  = 3'd2,
    ST_MISS  = 3'd3,
    ST_ERROR = 3'd4
  } status_t;

  typedef struct packed {
    func_t               func;
    logic                direct;
    logic [CODE_W-1:0]   code_point;
    logic [FLAGS_W-1:0]  entry_flags;
    logic [OFFSET_W-1:0] glyph_offset;
  } cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0]   code_point;
    logic [FLAGS_W-1:0]  entry_flags;
    logic [OFFSET_W-1:0] glyph_offset;
  } entry_t;

  typedef struct packed {
    status_t                status;
    logic                   found;
    logic [ENTRY_NUM_W-1:0] entry_number;
    logic [FLAGS_W-1:0]     found_flags;
    logic [OFFSET_W-1:0]    found_offset;
  } result_t;

endpackage

[rtl/cgi_front.sv]
// ----------------------------------------------------------------------------
// cgi_front: input stage of the glyph index lookup
// Accepts items from the input stream, decodes the item kind and marks codes
// that fall inside the direct-map span, then offers the command onwards.
// ----------------------------------------------------------------------------
module cgi_front #(
  parameter int DIRECT_SPAN = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cgi_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic [cgi_pkg::IN_TUSER_W-1:0]      s_tuser,
  output cgi_pkg::cmd_t                       cmd,
  output logic                                cmd_valid,
  input  logic                                cmd_ready
);
  import cgi_pkg::*;

  logic hold_valid;
  cmd_t decoded;

  always_comb begin
    decoded.func          = func_t'(s_tuser);
    decoded.code_point    = s_tdata[CODE_W-1:0];
    decoded.entry_flags   = s_tdata[CODE_W +: FLAGS_W];
    decoded.glyph_offset  = s_tdata[CODE_W + FLAGS_W +: OFFSET_W];
    decoded.direct        = s_tdata[CODE_W-1:0] < CODE_W'(DIRECT_SPAN);
  end

  assign s_tready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        hold_valid <= 1'b1;
      end else if (cmd_ready) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= decoded;
    end
  end

endmodule

[rtl/cgi_queue.sv]
// ----------------------------------------------------------------------------
// cgi_queue: command queue between front and back end
// A short first-in first-out buffer of decoded commands, so that the input
// side keeps taking items while the back end works on a long lookup.
// ----------------------------------------------------------------------------
module cgi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cgi_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output cgi_pkg::cmd_t out_cmd
);
  import cgi_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

[rtl/cgi_back.sv]
// ----------------------------------------------------------------------------
// cgi_back: table engine of the glyph index lookup
// Holds the sorted entry table and the direct map, carries out clear, load
// and lookup commands one at a time and presents one result per command.
// ----------------------------------------------------------------------------
module cgi_back #(
  parameter int MAX_ENTRIES = 4096,
  parameter int DIRECT_SPAN = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  cgi_pkg::cmd_t    cmd,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  output cgi_pkg::result_t res,
  output logic             res_valid,
  input  logic             res_ready
);
  import cgi_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = $clog2(DIRECT_SPAN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DMCHK,
    S_VERIFY,
    S_SEARCH,
    S_EMIT
  } state_t;

  state_t            state;
  logic [CW-1:0]     entry_count;
  logic [CODE_W-1:0] prev_code;
  logic              load_error;
  logic [CODE_W-1:0] cur_cp;
  logic [CW-1:0]     first;
  logic [CW-1:0]     len;
  logic [IW-1:0]     mid;

  // Entry table and direct map, both with registered reads.
  entry_t            tab_mem [MAX_ENTRIES];
  logic [IW-1:0]     dmap    [DIRECT_SPAN];
  entry_t            tab_q;
  logic [IW-1:0]     dm_q;

  logic              is_load;
  logic              table_full;
  logic              order_bad;
  logic              load_ok;
  logic [IW-1:0]     start_mid;
  logic              dm_in_range;
  logic              code_eq;
  logic              code_lt;
  logic [CW-1:0]     half;
  logic [CW-1:0]     first_n;
  logic [CW-1:0]     len_n;
  logic [IW-1:0]     mid_n;
  logic [IW-1:0]     rd_addr;
  entry_t            wr_entry;

  assign cmd_ready = state == S_IDLE;
  assign res_valid = state == S_EMIT;

  assign is_load    = (state == S_IDLE) && cmd_valid && (cmd.func == FUNC_LOAD);
  assign table_full = entry_count >= CW'(MAX_ENTRIES);
  assign order_bad  = (entry_count != '0) && (prev_code >= cmd.code_point);
  assign load_ok    = is_load && !load_error && !table_full && !order_bad;

  assign start_mid   = IW'(entry_count >> 1);
  assign dm_in_range = CW'(dm_q) < entry_count;
  assign code_eq     = tab_q.code_point == cur_cp;
  assign code_lt     = tab_q.code_point < cur_cp;
  assign half        = len >> 1;

  // One step of the binary search over the window [first, first + len).
  always_comb begin
    if (code_lt) begin
      first_n = CW'(mid) + CW'(1);
      len_n   = len - half - CW'(1);
    end else begin
      first_n = first;
      len_n   = half;
    end
    mid_n = IW'(first_n + (len_n >> 1));
  end

  // Table read address for the next cycle.
  always_comb begin
    unique case (state)
      S_IDLE:   rd_addr = start_mid;
      S_DMCHK: begin
        if (dm_in_range) begin
          rd_addr = dm_q;
        end else begin
          rd_addr = start_mid;
        end
      end
      S_VERIFY: rd_addr = start_mid;
      S_SEARCH: rd_addr = mid_n;
      S_EMIT:   rd_addr = mid;
      default:  rd_addr = mid;
    endcase
  end

  always_comb begin
    wr_entry.code_point    = cmd.code_point;
    wr_entry.entry_flags   = cmd.entry_flags;
    wr_entry.glyph_offset  = cmd.glyph_offset;
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      tab_mem[entry_count[IW-1:0]] <= wr_entry;
    end
    tab_q <= tab_mem[rd_addr];
  end

  // Entry numbers never reach 0xffff, so every in-span load is recorded.
  always_ff @(posedge clk) begin
    if (load_ok && cmd.direct) begin
      dmap[cmd.code_point[DW-1:0]] <= entry_count[IW-1:0];
    end
    if (state == S_IDLE) begin
      dm_q <= dmap[cmd.code_point[DW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      prev_code   <= '0;
      load_error  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res.status       <= ST_OK;
            res.found        <= 1'b0;
            res.entry_number <= '0;
            res.found_flags  <= '0;
            res.found_offset <= '0;
            cur_cp           <= cmd.code_point;
            state            <= S_EMIT;
            unique case (cmd.func)
              FUNC_CLEAR: begin
                entry_count <= '0;
                prev_code   <= '0;
                load_error  <= 1'b0;
              end
              FUNC_LOAD: begin
                if (load_error) begin
                  res.status <= ST_ERROR;
                end else if (table_full) begin
                  load_error <= 1'b1;
                  res.status <= ST_FULL;
                end else if (order_bad) begin
                  load_error <= 1'b1;
                  res.status <= ST_ORDER;
                end else begin
                  entry_count      <= entry_count + CW'(1);
                  prev_code        <= cmd.code_point;
                  res.entry_number <= ENTRY_NUM_W'(entry_count);
                end
              end
              FUNC_LOOKUP: begin
                if (load_error) begin
                  res.status <= ST_ERROR;
                end else if (cmd.direct) begin
                  state <= S_DMCHK;
                end else if (entry_count == '0) begin
                  res.status <= ST_MISS;
                end else begin
                  first <= '0;
                  len   <= entry_count;
                  mid   <= start_mid;
                  state <= S_SEARCH;
                end
              end
              FUNC_NONE: begin
              end
            endcase
          end
        end
        S_DMCHK: begin
          if (dm_in_range) begin
            mid   <= dm_q;
            state <= S_VERIFY;
          end else if (entry_count == '0) begin
            res.status <= ST_MISS;
            state      <= S_EMIT;
          end else begin
            first <= '0;
            len   <= entry_count;
            mid   <= start_mid;
            state <= S_SEARCH;
          end
        end
        S_VERIFY: begin
          // A slot left over from before a clear passes this check only when its entry
          // now holds the same code; otherwise the lookup falls back to the search.
          if (code_eq) begin
            res.found        <= 1'b1;
            res.entry_number <= ENTRY_NUM_W'(mid);
            res.found_flags  <= tab_q.entry_flags;
            res.found_offset <= tab_q.glyph_offset;
            state            <= S_EMIT;
          end else begin
            first <= '0;
            len   <= entry_count;
            mid   <= start_mid;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (code_eq) begin
            res.found        <= 1'b1;
            res.entry_number <= ENTRY_NUM_W'(mid);
            res.found_flags  <= tab_q.entry_flags;
            res.found_offset <= tab_q.glyph_offset;
            state            <= S_EMIT;
          end else if (len_n == '0) begin
            res.status <= ST_MISS;
            state      <= S_EMIT;
          end else begin
            first <= first_n;
            len   <= len_n;
            mid   <= mid_n;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/codepoint_glyph_index_lookup.sv]
// ----------------------------------------------------------------------------
// codepoint_glyph_index_lookup: character index engine for a bitmap font
// Builds a sorted table of glyph entries with a direct map for low codes and
// answers code point lookups through the direct map or a binary search.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | carries
//   --------+-----------+--------------------+-----------------------------
//   s_*     | in        | s_tvalid, s_tready | one command item (clear,
//           |           |                    | load or lookup)
//   m_*     | out       | m_tvalid, m_tready | one result item per command
//
// A clear, a load or an unused command goes from idle straight to presenting
// its result. A lookup in the direct-map span first reads the direct map and
// verifies the entry that it names; on a miss there, or for a code outside
// the span, the engine runs a binary search, one probe per cycle through the
// single read port of the entry table, and then presents the result.
// Reset is synchronous and needs no clearing pass: every direct-map slot is
// checked against the entry table before it is trusted, so stale or unwritten
// slots simply send the lookup to the search.
// Either side may stall: a two-item queue lets the input keep taking items
// while the engine is busy or its result waits.
//
module codepoint_glyph_index_lookup #(
  parameter int MAX_ENTRIES = 4096,
  parameter int DIRECT_SPAN = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata, from bit 0: code_point[31:0], entry_flags[7:0], glyph_offset[31:0]
  input  logic [cgi_pkg::IN_TDATA_W-1:0]    s_tdata,
  // s_tuser, from bit 0: func[1:0]
  input  logic [cgi_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata, from bit 0: found, entry_number[11:0], found_flags[7:0],
  // found_offset[31:0], then zero padding
  output logic [cgi_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // m_tuser, from bit 0: status[2:0]
  output logic [cgi_pkg::OUT_TUSER_W-1:0]   m_tuser
);
  import cgi_pkg::*;

  // Decoded commands travel from the input stage through the queue.
  cmd_t    front_cmd;
  logic    front_valid;
  logic    front_ready;
  cmd_t    queue_cmd;
  logic    queue_valid;
  logic    queue_ready;
  result_t result;

  cgi_front #(
    .DIRECT_SPAN (DIRECT_SPAN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  cgi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_cmd   (queue_cmd)
  );

  // The engine's result register is the output register of the block.
  cgi_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DIRECT_SPAN (DIRECT_SPAN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (queue_cmd),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .res       (result),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, result.found_offset, result.found_flags,
                    result.entry_number, result.found};
  assign m_tuser = result.status;

endmodule
